// File: rtl/vfst_pkg.sv
// ============================================================================
// vfst_pkg - shared types and constants of the field sequence tracker
// Field widths, operation and register codes, reset values and the structs
// that travel between the front end, the queue and the back end.
// ============================================================================
package vfst_pkg;

   // Defaults of the top level parameters
   localparam int RING_POSITIONS_DEFAULT = 10;
   localparam int STAMP_BITS_DEFAULT     = 48;
   localparam int FRACTION_BITS_DEFAULT  = 16;
   localparam int QUEUE_DEPTH_DEFAULT    = 2;

   // Fixed field widths
   localparam int POS_W       = 4;
   localparam int FRAME_W     = 3;
   localparam int CNT_W       = 32;
   localparam int PERIOD_W    = 32;
   localparam int WEIGHT_BITS = 16;
   localparam int OP_W        = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Samples wider than this many bits never pass the gate
   localparam int SAMPLE_LIMIT_BITS = 33;

   // Operation codes of a request beat
   localparam logic [OP_W-1:0] OP_FIELD     = 2'd0;
   localparam logic [OP_W-1:0] OP_RESTART   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLR_DROP  = 2'd2;
   localparam logic [OP_W-1:0] OP_CLR_USED  = 2'd3;

   // Register indexes of the control port
   localparam logic [CSR_INDEX_W-1:0] REG_ACCURATE_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_START_PERIOD  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_WEIGHT        = 2'd2;

   // Register reset values
   localparam logic [PERIOD_W-1:0]    RESET_START_PERIOD = 32'd119453;
   localparam logic [WEIGHT_BITS-1:0] RESET_WEIGHT       = 16'd328;

   // Command kinds decided by the front end
   typedef enum logic [2:0] {
      KIND_FIELD,
      KIND_RESTART,
      KIND_CLR_DROP,
      KIND_CLR_USED,
      KIND_SKIP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [POS_W-1:0]  position;
      logic              late_on_entry;
   } cmd_type;

   typedef struct packed {
      logic                   accurate_mode;
      logic [PERIOD_W-1:0]    start_period_ticks;
      logic [WEIGHT_BITS-1:0] weight_q16;
   } cfg_type;

   // Result of one new field, without the average
   typedef struct packed {
      logic [FRAME_W-1:0] frame_index;
      logic               is_odd_field;
      logic               missed_fields;
      logic               late_adjust;
      logic               field_late;
      logic [CNT_W-1:0]   dropped_total;
      logic [CNT_W-1:0]   used_total;
   } res_type;

   typedef struct packed {
      logic busy;
      logic sending;
   } back_stat_type;

endpackage

// File: rtl/vfst_channels.sv
// ============================================================================
// vfst channels - request and response stream interfaces
// Valid/ready channels; a beat moves at a clock edge with valid and ready high.
// ============================================================================
interface vfst_req_if #(
   parameter int STAMP_BITS = vfst_pkg::STAMP_BITS_DEFAULT
) ();
   import vfst_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       op;
   logic [POS_W-1:0]      position;
   logic [STAMP_BITS-1:0] timestamp;
   logic                  late_on_entry;

   modport source (output valid, op, position, timestamp, late_on_entry, input ready);
   modport sink   (input valid, op, position, timestamp, late_on_entry, output ready);
endinterface

interface vfst_rsp_if ();
   import vfst_pkg::*;

   logic                valid;
   logic                ready;
   logic [FRAME_W-1:0]  frame_index;
   logic                is_odd_field;
   logic                missed_fields;
   logic                late_adjust;
   logic                field_late;
   logic [CNT_W-1:0]    dropped_total;
   logic [CNT_W-1:0]    used_total;
   logic [PERIOD_W-1:0] average_period;

   modport source (output valid, frame_index, is_odd_field, missed_fields, late_adjust,
                   field_late, dropped_total, used_total, average_period, input ready);
   modport sink   (input valid, frame_index, is_odd_field, missed_fields, late_adjust,
                   field_late, dropped_total, used_total, average_period, output ready);
endinterface

// File: rtl/vfst_front.sv
// ============================================================================
// vfst_front - request decode
// Accepts request beats while the queue has room and turns each into a
// command kind: field event, restart, counter clear, or an ignored event.
// ============================================================================
module vfst_front #(
   parameter int RING_POSITIONS = vfst_pkg::RING_POSITIONS_DEFAULT,
   parameter int STAMP_BITS     = vfst_pkg::STAMP_BITS_DEFAULT
) (
   vfst_req_if.sink              req,
   input  logic                  q_full,
   output logic                  q_push,
   output vfst_pkg::cmd_type     q_cmd,
   output logic [STAMP_BITS-1:0] q_stamp
);
   import vfst_pkg::*;

   localparam logic [POS_W:0] RING_X = (POS_W+1)'(RING_POSITIONS);

   logic in_range;

   // Take a beat whenever the queue can hold it
   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   assign in_range  = {1'b0, req.position} < RING_X;

   // Classify the beat
   always_comb begin
      q_cmd.position      = req.position;
      q_cmd.late_on_entry = req.late_on_entry;
      unique case (req.op)
         OP_FIELD:    q_cmd.kind = in_range ? KIND_FIELD : KIND_SKIP;
         OP_RESTART:  q_cmd.kind = KIND_RESTART;
         OP_CLR_DROP: q_cmd.kind = KIND_CLR_DROP;
         OP_CLR_USED: q_cmd.kind = KIND_CLR_USED;
         default:     q_cmd.kind = KIND_SKIP;
      endcase
   end

   assign q_stamp = req.timestamp;

endmodule

// File: rtl/vfst_queue.sv
// ============================================================================
// vfst_queue - command queue between front and back end
// Small register FIFO; push and pop may happen in the same cycle.
// ============================================================================
module vfst_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = vfst_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] wdata,
   output logic              full,
   output logic              valid,
   output logic [DATA_W-1:0] rdata,
   input  logic              pop
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = count_ff == CNT_W'(DEPTH);
   assign valid   = count_ff != '0;
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: rtl/vfst_avg.sv
// ============================================================================
// vfst_avg - period average refinement unit
// Two register stages: gate the sample against the 5 percent window and
// form the distance, then multiply by the weight; the last stage rounds,
// moves the average toward the sample and saturates.
// ============================================================================
module vfst_avg #(
   parameter int STAMP_BITS    = vfst_pkg::STAMP_BITS_DEFAULT,
   parameter int FRACTION_BITS = vfst_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic [STAMP_BITS-1:0]                     sample,
   input  logic [vfst_pkg::PERIOD_W+FRACTION_BITS-1:0] avg_old,
   input  logic [vfst_pkg::WEIGHT_BITS-1:0]          weight,
   output logic                                      done,
   output logic                                      update,
   output logic [vfst_pkg::PERIOD_W+FRACTION_BITS-1:0] avg_new
);
   import vfst_pkg::*;

   localparam int AVG_W  = PERIOD_W + FRACTION_BITS;
   localparam int EXT_W  = STAMP_BITS + SAMPLE_LIMIT_BITS + 1;
   localparam int RQ_W   = SAMPLE_LIMIT_BITS + FRACTION_BITS;
   localparam int CMP_W  = RQ_W + 5;
   // A gated distance stays below avg/20, so this many bits hold it
   localparam int MUL_W  = AVG_W - 4;
   localparam int PROD_W = MUL_W + WEIGHT_BITS;
   localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (WEIGHT_BITS - 1);

   logic [EXT_W-1:0]  sample_x;
   logic              sample_ok;
   logic [RQ_W-1:0]   rq, avg_x;
   logic [CMP_W-1:0]  rq20, avg19, avg21;

   logic              s1_valid_ff;
   logic              s1_ok_ff;
   logic              s1_up_ff;
   logic [CMP_W-1:0]  s1_rq20_ff, s1_avg19_ff, s1_avg21_ff;
   logic [RQ_W-1:0]   s1_dist_ff;
   logic [AVG_W-1:0]  s1_avg_ff;

   logic              s2_valid_ff;
   logic              s2_gate_ff;
   logic              s2_up_ff;
   logic [PROD_W-1:0] s2_prod_ff;
   logic [AVG_W-1:0]  s2_avg_ff;

   logic              gate;
   logic [PROD_W-1:0] rounded;
   logic [MUL_W-1:0]  step;
   logic [AVG_W:0]    sum_up;
   logic [AVG_W-1:0]  sum_down;

   // Scale the sample and form 20*sample against 19*avg and 21*avg
   assign sample_x  = EXT_W'(sample);
   assign sample_ok = sample_x[EXT_W-1:SAMPLE_LIMIT_BITS] == '0;
   assign rq        = RQ_W'(sample_x[SAMPLE_LIMIT_BITS-1:0]) << FRACTION_BITS;
   assign avg_x     = RQ_W'(avg_old);
   assign rq20      = (CMP_W'(rq) << 4) + (CMP_W'(rq) << 2);
   assign avg19     = (CMP_W'(avg_old) << 4) + (CMP_W'(avg_old) << 1) + CMP_W'(avg_old);
   assign avg21     = (CMP_W'(avg_old) << 4) + (CMP_W'(avg_old) << 2) + CMP_W'(avg_old);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Stage one: window terms and distance
   always_ff @(posedge clock) begin
      s1_ok_ff    <= sample_ok;
      s1_up_ff    <= rq > avg_x;
      s1_rq20_ff  <= rq20;
      s1_avg19_ff <= avg19;
      s1_avg21_ff <= avg21;
      s1_dist_ff  <= (rq > avg_x) ? rq - avg_x : avg_x - rq;
      s1_avg_ff   <= avg_old;
   end

   assign gate = s1_ok_ff && (s1_rq20_ff > s1_avg19_ff) && (s1_rq20_ff < s1_avg21_ff);

   // Stage two: weight the distance
   always_ff @(posedge clock) begin
      s2_gate_ff <= gate;
      s2_up_ff   <= s1_up_ff;
      s2_prod_ff <= PROD_W'(s1_dist_ff[MUL_W-1:0]) * PROD_W'(weight);
      s2_avg_ff  <= s1_avg_ff;
   end

   // Round half up, then move toward the sample
   assign rounded  = s2_prod_ff + HALF;
   assign step     = rounded[PROD_W-1:WEIGHT_BITS];
   assign sum_up   = (AVG_W+1)'(s2_avg_ff) + (AVG_W+1)'(step);
   assign sum_down = s2_avg_ff - AVG_W'(step);

   always_comb begin
      if (s2_up_ff) begin
         avg_new = sum_up[AVG_W] ? '1 : sum_up[AVG_W-1:0];
      end else begin
         avg_new = sum_down;
      end
   end

   assign done   = s2_valid_ff;
   assign update = s2_gate_ff;

endmodule

// File: rtl/vfst_back.sv
// ============================================================================
// vfst_back - field sequence execution
// Holds the tracker state, drives the response register and carries out one
// queued command per cycle unless refining or held by the response register.
// Refining fields hand the sample to the average unit, then send their beat.
// ============================================================================
module vfst_back #(
   parameter int RING_POSITIONS = vfst_pkg::RING_POSITIONS_DEFAULT,
   parameter int STAMP_BITS     = vfst_pkg::STAMP_BITS_DEFAULT,
   parameter int FRACTION_BITS  = vfst_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  vfst_pkg::cmd_type       q_cmd,
   input  logic [STAMP_BITS-1:0]   q_stamp,
   output logic                    q_pop,
   input  vfst_pkg::cfg_type       cfg,
   output vfst_pkg::back_stat_type stat,
   vfst_rsp_if.source              rsp
);
   import vfst_pkg::*;

   localparam int AVG_W = PERIOD_W + FRACTION_BITS;
   localparam logic [POS_W:0]   RING_X    = (POS_W+1)'(RING_POSITIONS);
   localparam logic [POS_W-1:0] RING_LAST = POS_W'(RING_POSITIONS - 1);
   localparam logic [AVG_W-1:0] RESET_AVG = AVG_W'(RESET_START_PERIOD) << FRACTION_BITS;

   localparam logic [1:0] ST_EXEC = 2'd0;
   localparam logic [1:0] ST_AVG  = 2'd1;
   localparam logic [1:0] ST_SEND = 2'd2;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [POS_W-1:0] b);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
      return s[CNT_W] ? '1 : s[CNT_W-1:0];
   endfunction

   logic [1:0]            state_ff, state_in;
   logic [POS_W-1:0]      cur_pos_ff, cur_pos_in;
   logic                  waited_ff, waited_in;
   logic [STAMP_BITS-1:0] stamp_ff, stamp_in;
   logic                  stamp_valid_ff, stamp_valid_in;
   logic [AVG_W-1:0]      avg_ff, avg_in;
   logic [CNT_W-1:0]      dropped_ff, dropped_in;
   logic [CNT_W-1:0]      used_ff, used_in;
   res_type               pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   res_type               res_ff, res_in;
   logic [PERIOD_W-1:0]   period_ff, period_in;

   logic                  out_free, rsp_load;
   logic [POS_W:0]        diff_sum;
   logic [POS_W-1:0]      diff, next_pos, take_pos, prev_pos, drop_add;
   logic                  adjust, missed, late, used_en;
   logic                  stamp_kill, stamp_load, refine;
   res_type               result;
   logic                  avg_start, avg_done, avg_update;
   logic [AVG_W-1:0]      avg_new;
   logic [STAMP_BITS-1:0] sample;

   assign out_free = !rsp_valid_ff || rsp.ready;

   // Ring distance and next slot
   assign diff_sum = {1'b0, q_cmd.position} + RING_X - {1'b0, cur_pos_ff};
   assign diff     = (diff_sum >= RING_X) ? POS_W'(diff_sum - RING_X) : POS_W'(diff_sum);
   assign next_pos = (cur_pos_ff == RING_LAST) ? '0 : cur_pos_ff + 1'b1;
   assign sample   = q_stamp - stamp_ff;

   // Classify the new field
   always_comb begin
      take_pos   = q_cmd.position;
      adjust     = 1'b0;
      missed     = 1'b0;
      late       = 1'b0;
      drop_add   = '0;
      used_en    = 1'b0;
      stamp_kill = 1'b0;
      stamp_load = 1'b0;
      refine     = 1'b0;
      if (cfg.accurate_mode) begin
         if (diff == POS_W'(2) || diff == POS_W'(3)) begin
            take_pos = next_pos;
            adjust   = 1'b1;
         end else if (diff != POS_W'(1)) begin
            missed     = 1'b1;
            drop_add   = diff - 1'b1;
            stamp_kill = 1'b1;
         end
         if (!take_pos[0]) begin
            if (waited_ff) begin
               stamp_load = 1'b1;
               refine     = stamp_valid_ff && !missed;
            end else begin
               stamp_kill = 1'b1;
            end
         end
         used_en = 1'b1;
      end else begin
         late = q_cmd.late_on_entry && !waited_ff;
         if (diff > POS_W'(1)) begin
            missed   = 1'b1;
            drop_add = diff - 1'b1;
         end else if (late) begin
            drop_add = POS_W'(1);
         end
         used_en = !late;
      end
   end

   assign prev_pos = (take_pos == '0) ? RING_LAST : take_pos - 1'b1;

   always_comb begin
      result.frame_index   = FRAME_W'(prev_pos >> 1);
      result.is_odd_field  = !take_pos[0];
      result.missed_fields = missed;
      result.late_adjust   = adjust;
      result.field_late    = late;
      result.dropped_total = sat_add(dropped_ff, drop_add);
      result.used_total    = used_en ? sat_add(used_ff, POS_W'(1)) : used_ff;
   end

   // Sequence commands
   always_comb begin
      state_in       = state_ff;
      cur_pos_in     = cur_pos_ff;
      waited_in      = waited_ff;
      stamp_in       = stamp_ff;
      stamp_valid_in = stamp_valid_ff;
      avg_in         = avg_ff;
      dropped_in     = dropped_ff;
      used_in        = used_ff;
      pend_in        = pend_ff;
      res_in         = res_ff;
      period_in      = period_ff;
      q_pop          = 1'b0;
      rsp_load       = 1'b0;
      avg_start      = 1'b0;
      unique case (state_ff)
         ST_EXEC: begin
            if (q_valid) begin
               unique case (q_cmd.kind)
                  KIND_RESTART: begin
                     q_pop          = 1'b1;
                     avg_in         = AVG_W'(cfg.start_period_ticks) << FRACTION_BITS;
                     stamp_valid_in = 1'b0;
                  end
                  KIND_CLR_DROP: begin
                     q_pop      = 1'b1;
                     dropped_in = '0;
                  end
                  KIND_CLR_USED: begin
                     q_pop   = 1'b1;
                     used_in = '0;
                  end
                  KIND_SKIP: begin
                     q_pop = 1'b1;
                  end
                  KIND_FIELD: begin
                     if (q_cmd.position == cur_pos_ff) begin
                        q_pop     = 1'b1;
                        waited_in = 1'b1;
                     end else if (refine || out_free) begin
                        q_pop      = 1'b1;
                        cur_pos_in = take_pos;
                        waited_in  = 1'b0;
                        dropped_in = result.dropped_total;
                        used_in    = result.used_total;
                        if (stamp_load) begin
                           stamp_in       = q_stamp;
                           stamp_valid_in = 1'b1;
                        end else if (stamp_kill) begin
                           stamp_valid_in = 1'b0;
                        end
                        if (refine) begin
                           avg_start = 1'b1;
                           pend_in   = result;
                           state_in  = ST_AVG;
                        end else begin
                           rsp_load  = 1'b1;
                           res_in    = result;
                           period_in = avg_ff[AVG_W-1:FRACTION_BITS];
                        end
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_AVG: begin
            if (avg_done) begin
               if (avg_update) begin
                  avg_in = avg_new;
               end
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_load  = 1'b1;
               res_in    = pend_ff;
               period_in = avg_ff[AVG_W-1:FRACTION_BITS];
               state_in  = ST_EXEC;
            end
         end
         default: begin
            state_in = ST_EXEC;
         end
      endcase
   end

   // Hold the response beat until taken
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_EXEC;
         cur_pos_ff     <= '0;
         waited_ff      <= 1'b0;
         stamp_valid_ff <= 1'b0;
         avg_ff         <= RESET_AVG;
         dropped_ff     <= '0;
         used_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cur_pos_ff     <= cur_pos_in;
         waited_ff      <= waited_in;
         stamp_valid_ff <= stamp_valid_in;
         avg_ff         <= avg_in;
         dropped_ff     <= dropped_in;
         used_ff        <= used_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stamp_ff  <= stamp_in;
      pend_ff   <= pend_in;
      res_ff    <= res_in;
      period_ff <= period_in;
   end

   vfst_avg #(
      .STAMP_BITS    (STAMP_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_avg (
      .clock   (clock),
      .reset   (reset),
      .start   (avg_start),
      .sample  (sample),
      .avg_old (avg_ff),
      .weight  (cfg.weight_q16),
      .done    (avg_done),
      .update  (avg_update),
      .avg_new (avg_new)
   );

   assign stat.busy    = state_ff != ST_EXEC;
   assign stat.sending = state_ff == ST_SEND;

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.frame_index    = res_ff.frame_index;
   assign rsp.is_odd_field   = res_ff.is_odd_field;
   assign rsp.missed_fields  = res_ff.missed_fields;
   assign rsp.late_adjust    = res_ff.late_adjust;
   assign rsp.field_late     = res_ff.field_late;
   assign rsp.dropped_total  = res_ff.dropped_total;
   assign rsp.used_total     = res_ff.used_total;
   assign rsp.average_period = period_ff;

endmodule

// File: rtl/video_field_sequence_tracker.sv
// ============================================================================
// video_field_sequence_tracker - capture field sequence and period tracker
// Follows a capture engine around a ring of field positions, counts dropped
// and used fields and keeps a fixed point average of the frame period.
//
//   channel  | dir | beat                               | handshake
//   ---------+-----+------------------------------------+-------------
//   req_ch   | in  | op, position, timestamp, late flag | valid/ready
//   rsp_ch   | out | frame slot, flags, counts, average | valid/ready
//   csr_*    | in  | register index and write data      | write enable
//
// One request beat per cycle while the queue has room; the beat of a field
// that does not refine the average reaches the response register the cycle
// after the back end takes it. An accurate-mode odd field that refines the
// average holds the back end through the two average unit stages and a send
// state, while the queue takes beats until full. Reset is synchronous and
// clears the control state. A stalled response stalls the back end only for
// fields that give a beat; the queue then fills and drops req_ch.ready.
// ============================================================================
module video_field_sequence_tracker #(
   parameter int RING_POSITIONS = vfst_pkg::RING_POSITIONS_DEFAULT,
   parameter int STAMP_BITS     = vfst_pkg::STAMP_BITS_DEFAULT,
   parameter int FRACTION_BITS  = vfst_pkg::FRACTION_BITS_DEFAULT,
   parameter int QUEUE_DEPTH    = vfst_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   vfst_req_if.sink                           req_ch,
   vfst_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [vfst_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [vfst_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import vfst_pkg::*;

   localparam int CMD_W = $bits(cmd_type);
   localparam int Q_W   = CMD_W + STAMP_BITS;

   cfg_type               cfg_ff, cfg_in;
   logic                  q_push, q_full, q_valid, q_pop;
   cmd_type               f_cmd, b_cmd;
   logic [STAMP_BITS-1:0] f_stamp, b_stamp;
   logic [Q_W-1:0]        q_wdata, q_rdata;
   back_stat_type         bstat;

   // Write control registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_ACCURATE_MODE: cfg_in.accurate_mode      = csr_wdata[0];
            REG_START_PERIOD:  cfg_in.start_period_ticks = csr_wdata[PERIOD_W-1:0];
            REG_WEIGHT:        cfg_in.weight_q16         = csr_wdata[WEIGHT_BITS-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accurate_mode      <= 1'b0;
         cfg_ff.start_period_ticks <= RESET_START_PERIOD;
         cfg_ff.weight_q16         <= RESET_WEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vfst_front #(
      .RING_POSITIONS (RING_POSITIONS),
      .STAMP_BITS     (STAMP_BITS)
   ) u_front (
      .req     (req_ch),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_cmd   (f_cmd),
      .q_stamp (f_stamp)
   );

   assign q_wdata = {f_cmd, f_stamp};

   vfst_queue #(
      .DATA_W (Q_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .valid (q_valid),
      .rdata (q_rdata),
      .pop   (q_pop)
   );

   assign b_cmd   = cmd_type'(q_rdata[Q_W-1:STAMP_BITS]);
   assign b_stamp = q_rdata[STAMP_BITS-1:0];

   vfst_back #(
      .RING_POSITIONS (RING_POSITIONS),
      .STAMP_BITS     (STAMP_BITS),
      .FRACTION_BITS  (FRACTION_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (b_cmd),
      .q_stamp (b_stamp),
      .q_pop   (q_pop),
      .cfg     (cfg_ff),
      .stat    (bstat),
      .rsp     (rsp_ch)
   );

   // Response register starts empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("response valid after reset");

   // Queue is drained only while the back end is free
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      bstat.busy |-> !q_pop)
      else $error("queue popped while back end busy");

   // A pending refined beat goes out once the register is free
   a_send: assert property (@(posedge clock) disable iff (reset)
      (bstat.sending && !rsp_ch.valid) |=> rsp_ch.valid)
      else $error("refined beat not sent");

   // A beat pushed into an empty queue is visible next cycle
   a_queue_fill: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_valid) |=> q_valid)
      else $error("queue lost a beat");

endmodule

// File: dv/tb_video_field_sequence_tracker.sv
// ============================================================================
// tb_video_field_sequence_tracker - self-checking bench of the field tracker
// A queue-fed driver sends request beats with random gaps. A shadow tracker
// predicts each field result: ring position, counters and the fixed point
// period average. A monitor with random stalls compares every response beat
// with the oldest prediction. The run goes through directed cases, then
// random phases under several register settings.
// ============================================================================
`timescale 1ns / 1ps

module tb_video_field_sequence_tracker;
   import vfst_pkg::*;

   localparam int RING           = RING_POSITIONS_DEFAULT;
   localparam int STAMP_W        = STAMP_BITS_DEFAULT;
   localparam int WATCHDOG_LIMIT = 400;
   localparam int PHASES         = 8;
   localparam int PHASE_BEATS    = 120;
   localparam int SETTLE_CYCLES  = 12;
   localparam logic [63:0] AVG_MAX = (64'd1 << (CNT_W + FRACTION_BITS_DEFAULT)) - 64'd1;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [POS_W-1:0]   position;
      logic [STAMP_W-1:0] timestamp;
      logic               late_on_entry;
   } req_beat_type;

   typedef struct packed {
      logic [FRAME_W-1:0]  frame_index;
      logic                is_odd_field;
      logic                missed_fields;
      logic                late_adjust;
      logic                field_late;
      logic [CNT_W-1:0]    dropped_total;
      logic [CNT_W-1:0]    used_total;
      logic [PERIOD_W-1:0] average_period;
   } field_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Bench-side drive registers
   logic                   drv_valid = 1'b0;
   logic [OP_W-1:0]        drv_op    = OP_FIELD;
   logic [POS_W-1:0]       drv_pos   = '0;
   logic [STAMP_W-1:0]     drv_stamp = '0;
   logic                   drv_late  = 1'b0;
   logic                   drv_ready = 1'b0;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = REG_ACCURATE_MODE;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   vfst_req_if #(.STAMP_BITS(STAMP_W)) req_ch ();
   vfst_rsp_if rsp_ch ();

   assign req_ch.valid         = drv_valid;
   assign req_ch.op            = drv_op;
   assign req_ch.position      = drv_pos;
   assign req_ch.timestamp     = drv_stamp;
   assign req_ch.late_on_entry = drv_late;
   assign rsp_ch.ready         = drv_ready;

   video_field_sequence_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the registers
   logic                   cfg_accurate = 1'b0;
   logic [PERIOD_W-1:0]    cfg_start    = RESET_START_PERIOD;
   logic [WEIGHT_BITS-1:0] cfg_weight   = RESET_WEIGHT;

   // Shadow copy of the tracker state
   logic [POS_W-1:0]   ring_pos    = '0;
   logic               waited      = 1'b0;
   logic [STAMP_W-1:0] last_stamp  = '0;
   logic               stamp_ok    = 1'b0;
   logic [STAMP_W-1:0] avg_q       = {RESET_START_PERIOD, 16'd0};
   logic [CNT_W-1:0]   dropped_cnt = '0;
   logic [CNT_W-1:0]   used_cnt    = '0;

   req_beat_type     pending_beats[$];
   field_report_type fields_expected[$];
   req_beat_type     held_beat;
   logic             req_busy = 1'b0;
   logic             calm = 1'b0;
   int               req_gap = 0;
   int               rsp_stall = 0;
   int               quiet_cycles = 0;
   int               error_count = 0;
   int               beats_sent = 0;
   int               reports_checked = 0;
   int               avg_updates = 0;
   int               adjusts_seen = 0;

   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, 10);
   endfunction

   function automatic logic [STAMP_W-1:0] rand_stamp();
      return STAMP_W'({$urandom, $urandom});
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
   endfunction

   task automatic flag_error(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         flag_error($sformatf("%s got %0d, expected %0d", name, got, want));
   endtask

   // Fold one odd-to-odd period sample into the Q16 average
   function automatic void refine_period(input logic [STAMP_W-1:0] stamp);
      logic [63:0] r, rq, avg, m, step;
      if (stamp_ok) begin
         r   = {16'd0, stamp - last_stamp};
         avg = {16'd0, avg_q};
         if (r[63:SAMPLE_LIMIT_BITS] == '0) begin
            rq = r << FRACTION_BITS_DEFAULT;
            // take only samples within 5 percent of the average
            if (rq * 20 > avg * 19 && rq * 20 < avg * 21) begin
               m    = (rq > avg) ? rq - avg : avg - rq;
               step = (m >> 16) * cfg_weight + (((m & 64'hFFFF) * cfg_weight + 64'h8000) >> 16);
               if (rq > avg) begin
                  avg = avg + step;
                  if (avg > AVG_MAX) avg = AVG_MAX;
               end else begin
                  avg = avg - step;
               end
               avg_q = avg[STAMP_W-1:0];
               avg_updates++;
            end
         end
      end
      last_stamp = stamp;
      stamp_ok   = 1'b1;
   endfunction

   // Apply one accepted request beat to the shadow state
   function automatic void advance_tracker(input req_beat_type b);
      int               pos, diff;
      logic             late, missed, adjust;
      field_report_type rpt;
      pos    = int'(b.position);
      late   = b.late_on_entry;
      missed = 1'b0;
      adjust = 1'b0;
      case (b.op)
         OP_RESTART: begin
            avg_q      = {cfg_start, 16'd0};
            last_stamp = '0;
            stamp_ok   = 1'b0;
         end
         OP_CLR_DROP: dropped_cnt = '0;
         OP_CLR_USED: used_cnt = '0;
         default: begin
            if (pos < RING) begin
               if (pos == ring_pos) begin
                  // poll at the stored position
                  waited = 1'b1;
               end else begin
                  diff = (pos + RING - ring_pos) % RING;
                  if (cfg_accurate) begin
                     late = !waited;
                     if (diff == 2 || diff == 3) begin
                        pos    = (ring_pos + 1) % RING;
                        adjust = 1'b1;
                     end else if (diff != 1) begin
                        missed      = 1'b1;
                        dropped_cnt = sat_add(dropped_cnt, diff - 1);
                        last_stamp  = '0;
                        stamp_ok    = 1'b0;
                     end
                     if (pos % 2 == 0) begin
                        if (!late) begin
                           refine_period(b.timestamp);
                        end else begin
                           last_stamp = '0;
                           stamp_ok   = 1'b0;
                        end
                     end
                     late = 1'b0;
                  end else begin
                     if (waited) late = 1'b0;
                     if (diff > 1) begin
                        missed      = 1'b1;
                        dropped_cnt = sat_add(dropped_cnt, diff - 1);
                     end else if (late) begin
                        dropped_cnt = sat_add(dropped_cnt, 1);
                     end
                  end
                  if (!late) used_cnt = sat_add(used_cnt, 1);
                  ring_pos = POS_W'(pos);
                  waited   = 1'b0;
                  if (adjust) adjusts_seen++;
                  rpt.frame_index    = FRAME_W'(((pos + RING - 1) % RING) / 2);
                  rpt.is_odd_field   = (pos % 2 == 0);
                  rpt.missed_fields  = missed;
                  rpt.late_adjust    = adjust;
                  rpt.field_late     = late;
                  rpt.dropped_total  = dropped_cnt;
                  rpt.used_total     = used_cnt;
                  rpt.average_period = avg_q[STAMP_W-1:FRACTION_BITS_DEFAULT];
                  fields_expected.push_back(rpt);
               end
            end
         end
      endcase
   endfunction

   // Request driver: present queued beats, retire them on the handshake
   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
         req_busy = 1'b0;
         req_gap  = 0;
      end else begin
         // retire the beat that moved at this edge
         if (req_busy && req_ch.ready) begin
            advance_tracker(held_beat);
            beats_sent++;
            req_busy = 1'b0;
            req_gap  = draw_gap();
         end
         // load the next beat once its gap has passed
         if (!req_busy) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_beats.size() > 0) begin
               held_beat = pending_beats.pop_front();
               req_busy  = 1'b1;
            end
         end
         drv_valid <= req_busy;
         if (req_busy) begin
            drv_op    <= held_beat.op;
            drv_pos   <= held_beat.position;
            drv_stamp <= held_beat.timestamp;
            drv_late  <= held_beat.late_on_entry;
         end
      end
   end

   // Response monitor: compare each beat with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         drv_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_ch.valid && drv_ready) begin
            if (fields_expected.size() == 0) begin
               flag_error("response beat with no field result pending");
            end else begin
               field_report_type want;
               want = fields_expected.pop_front();
               check_field("frame_index", 32'(rsp_ch.frame_index), 32'(want.frame_index));
               check_field("is_odd_field", 32'(rsp_ch.is_odd_field), 32'(want.is_odd_field));
               check_field("missed_fields", 32'(rsp_ch.missed_fields),
                           32'(want.missed_fields));
               check_field("late_adjust", 32'(rsp_ch.late_adjust), 32'(want.late_adjust));
               check_field("field_late", 32'(rsp_ch.field_late), 32'(want.field_late));
               check_field("dropped_total", rsp_ch.dropped_total, want.dropped_total);
               check_field("used_total", rsp_ch.used_total, want.used_total);
               check_field("average_period", rsp_ch.average_period, want.average_period);
               reports_checked++;
            end
            rsp_stall = draw_gap();
         end
         // hold ready low for the drawn stall
         if (rsp_stall > 0) begin
            rsp_stall--;
            drv_ready <= 1'b0;
         end else begin
            drv_ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when no beat moves for too long
   always @(posedge clock) begin
      if ((drv_valid && req_ch.ready) || (rsp_ch.valid && drv_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles, %0d results pending",
                  quiet_cycles, fields_expected.size());
         $display("tb_video_field_sequence_tracker NOT OK");
         $finish;
      end
   end

   task automatic push_beat(input logic [OP_W-1:0] op, input int pos,
                            input logic [STAMP_W-1:0] stamp, input logic late);
      req_beat_type b;
      b.op            = op;
      b.position      = POS_W'(pos);
      b.timestamp     = stamp;
      b.late_on_entry = late;
      pending_beats.push_back(b);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_ACCURATE_MODE: cfg_accurate = data[0];
         REG_START_PERIOD:  cfg_start    = data;
         REG_WEIGHT:        cfg_weight   = data[WEIGHT_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait until every beat is sent and answered, then let the back end settle
   task automatic drain();
      while (pending_beats.size() != 0 || req_busy || fields_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Position the block will hold after a new field aimed at tgt
   function automatic int next_ring_pos(input int cur, input int tgt);
      int diff;
      diff = (tgt + RING - cur) % RING;
      if (diff == 0) return cur;
      if (cfg_accurate && (diff == 2 || diff == 3)) return (cur + 1) % RING;
      return tgt;
   endfunction

   // Random phase: mostly clean field sequences at the configured period
   task automatic gen_phase(input int quota);
      int                 made, pick, jump, tgt, gen_pos;
      logic [63:0]        half, span, step_ticks;
      logic [STAMP_W-1:0] gen_time;
      made     = 0;
      gen_pos  = int'(ring_pos);
      gen_time = rand_stamp();
      half     = 64'(cfg_start >> 1);
      if (half == 0) half = 1;
      span     = half / 6;
      push_beat(OP_RESTART, $urandom_range(0, 15), rand_stamp(), rand_bit());
      while (made < quota) begin
         pick       = $urandom_range(0, 99);
         step_ticks = half - span / 2 + $urandom_range(0, span[31:0]);
         if (pick < 70) begin
            // poll most of the time, then advance one slot
            if ($urandom_range(0, 4) != 0) begin
               push_beat(OP_FIELD, gen_pos, gen_time, rand_bit());
               made++;
            end
            gen_time = gen_time + STAMP_W'(step_ticks);
            tgt      = (gen_pos + 1) % RING;
            push_beat(OP_FIELD, tgt, gen_time, rand_bit());
            gen_pos  = tgt;
         end else if (pick < 80) begin
            jump     = $urandom_range(2, RING - 1);
            tgt      = (gen_pos + jump) % RING;
            gen_time = gen_time + STAMP_W'(step_ticks * jump);
            push_beat(OP_FIELD, tgt, gen_time, rand_bit());
            gen_pos  = next_ring_pos(gen_pos, tgt);
         end else if (pick < 88) begin
            push_beat(OP_W'($urandom_range(OP_RESTART, OP_CLR_USED)), $urandom_range(0, 15),
                      rand_stamp(), rand_bit());
         end else if (pick < 93) begin
            // out of range positions are ignored and not counted
            push_beat(OP_FIELD, $urandom_range(RING, 15), rand_stamp(), rand_bit());
            made--;
         end else begin
            tgt     = $urandom_range(0, RING - 1);
            push_beat(OP_FIELD, tgt, rand_stamp(), rand_bit());
            gen_pos = next_ring_pos(gen_pos, tgt);
         end
         made++;
      end
   endtask

   initial begin
      logic [STAMP_W-1:0] t0, t1;
      logic [CSR_DATA_W-1:0] start_sel, weight_sel;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Normal mode at reset settings: polls, late fields, skips, ignored positions
      push_beat(OP_FIELD, 0, 48'd100, 1'b0);
      push_beat(OP_FIELD, 1, 48'd200, 1'b1);
      push_beat(OP_FIELD, 2, 48'd300, 1'b1);
      push_beat(OP_FIELD, 5, 48'd0, 1'b0);
      push_beat(OP_FIELD, 4, {STAMP_W{1'b1}}, 1'b1);
      push_beat(OP_FIELD, 15, rand_stamp(), 1'b1);
      push_beat(OP_FIELD, RING, rand_stamp(), 1'b0);
      push_beat(OP_CLR_DROP, 0, 48'd0, 1'b0);
      push_beat(OP_FIELD, 5, 48'd400, 1'b0);
      push_beat(OP_CLR_USED, 9, 48'd0, 1'b1);
      push_beat(OP_RESTART, 15, {STAMP_W{1'b1}}, 1'b1);
      push_beat(OP_FIELD, 6, 48'd500, 1'b1);
      drain();

      // Accurate mode at the top period and full weight: adjusts, saturation, wrap
      write_reg(REG_ACCURATE_MODE, 32'd1);
      write_reg(REG_START_PERIOD, 32'hFFFF_FFFF);
      write_reg(REG_WEIGHT, 32'd65535);
      t0 = 48'hFFFF_0000_0000;
      t1 = t0 + 48'h1_0800_0000;
      push_beat(OP_FIELD, 6, 48'd0, 1'b0);
      push_beat(OP_FIELD, 8, 48'd0, 1'b0);
      push_beat(OP_FIELD, 7, 48'd0, 1'b0);
      push_beat(OP_FIELD, 8, t0, 1'b0);
      push_beat(OP_FIELD, 8, t0, 1'b1);
      push_beat(OP_FIELD, 1, t0, 1'b0);
      push_beat(OP_FIELD, 9, t0, 1'b0);
      push_beat(OP_FIELD, 0, t1, 1'b0);
      push_beat(OP_FIELD, 0, t1, 1'b0);
      push_beat(OP_FIELD, 1, t1, 1'b1);
      push_beat(OP_FIELD, 1, t1, 1'b0);
      push_beat(OP_FIELD, 2, t1 + 48'h2_0000_0000, 1'b0);
      push_beat(OP_FIELD, 7, t1, 1'b0);
      push_beat(OP_FIELD, 8, t1, 1'b0);
      drain();

      // Random phases over a spread of register settings
      for (int k = 0; k < PHASES; k++) begin
         start_sel  = k % 4;
         weight_sel = (k / 2) % 4;
         calm       = ($urandom_range(0, 3) == 0);
         write_reg(REG_ACCURATE_MODE, CSR_DATA_W'(k % 3 != 0));
         case (start_sel)
            0:       write_reg(REG_START_PERIOD, 32'd1);
            1:       write_reg(REG_START_PERIOD, 32'hFFFF_FFFF);
            2:       write_reg(REG_START_PERIOD, RESET_START_PERIOD);
            default: write_reg(REG_START_PERIOD, $urandom_range(64, 1 << 20));
         endcase
         case (weight_sel)
            0:       write_reg(REG_WEIGHT, 32'd0);
            1:       write_reg(REG_WEIGHT, 32'd65535);
            2:       write_reg(REG_WEIGHT, CSR_DATA_W'(RESET_WEIGHT));
            default: write_reg(REG_WEIGHT, $urandom_range(1, 65534));
         endcase
         gen_phase(PHASE_BEATS);
         drain();
      end
      repeat (20) @(posedge clock);

      $display("covered %0d request beats and %0d field results over %0d register settings",
               beats_sent, reports_checked, PHASES + 2);
      $display("average refined %0d times, %0d late adjusts, %0d mismatches",
               avg_updates, adjusts_seen, error_count);
      if (error_count == 0) begin
         $display("tb_video_field_sequence_tracker OK");
      end else begin
         $display("tb_video_field_sequence_tracker NOT OK");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/vfst_pkg.sv
rtl/vfst_channels.sv
rtl/vfst_front.sv
rtl/vfst_queue.sv
rtl/vfst_avg.sv
rtl/vfst_back.sv
rtl/video_field_sequence_tracker.sv
dv/tb_video_field_sequence_tracker.sv
